@@ design/logic_rotate_unit_8bit_assert.svh @@
// Assertion helpers for the module that checks its own logic.
// Each macro expects clk and rst_n to be in scope.
`ifndef LOGIC_ROTATE_UNIT_8BIT_ASSERT_SVH
`define LOGIC_ROTATE_UNIT_8BIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRU_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru assertion failed");

// The expression must never be true out of reset.
`define LRU_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lru assertion failed");

`endif

@@ design/lru_pkg.sv @@
`timescale 1ns / 1ps

package lru_pkg;

    localparam int unsigned FuncWidth = 4;
    localparam int unsigned DataWidth = 8;

    localparam logic [FuncWidth-1:0] FUNC_CMA = 4'd0;
    localparam logic [FuncWidth-1:0] FUNC_RLC = 4'd1;
    localparam logic [FuncWidth-1:0] FUNC_RRC = 4'd2;
    localparam logic [FuncWidth-1:0] FUNC_RAL = 4'd3;
    localparam logic [FuncWidth-1:0] FUNC_RAR = 4'd4;
    localparam logic [FuncWidth-1:0] FUNC_ANA = 4'd5;
    localparam logic [FuncWidth-1:0] FUNC_CMP = 4'd6;
    localparam logic [FuncWidth-1:0] FUNC_STC = 4'd7;
    localparam logic [FuncWidth-1:0] FUNC_CMC = 4'd8;

    typedef struct packed {
        logic [FuncWidth-1:0] func;
        logic [DataWidth-1:0] acc_in;
        logic [DataWidth-1:0] operand;
        logic                 carry_in;
    } req_t;

    typedef struct packed {
        logic [DataWidth-1:0] acc_out;
        logic                 carry_out;
        logic                 sign_out;
        logic                 zero_out;
        logic                 sz_written;
    } rsp_t;

endpackage

@@ design/lru_if.sv @@
`timescale 1ns / 1ps

interface lru_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] func;
    logic [7:0] acc_in;
    logic [7:0] operand;
    logic       carry_in;

    modport source (output valid, output func, output acc_in, output operand,
                    output carry_in, input ready);
    modport sink (input valid, input func, input acc_in, input operand,
                  input carry_in, output ready);
endinterface

interface lru_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] acc_out;
    logic       carry_out;
    logic       sign_out;
    logic       zero_out;
    logic       sz_written;

    modport source (output valid, output acc_out, output carry_out, output sign_out,
                    output zero_out, output sz_written, input ready);
    modport sink (input valid, input acc_out, input carry_out, input sign_out,
                  input zero_out, input sz_written, output ready);
endinterface

@@ design/lru_in_stage.sv @@
`timescale 1ns / 1ps

module lru_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  lru_pkg::req_t up_data,
    output logic          down_valid,
    input  logic          down_ready,
    output lru_pkg::req_t down_data
);
    import lru_pkg::*;

    logic valid_reg;
    req_t data_reg;

    // The stage refills in the same cycle that its beat moves on.
    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

endmodule

@@ design/lru_alu.sv @@
`timescale 1ns / 1ps

module lru_alu (
    input  lru_pkg::req_t req,
    output lru_pkg::rsp_t rsp
);
    import lru_pkg::*;

    always_comb
    begin
        rsp.acc_out    = req.acc_in;
        rsp.carry_out  = req.carry_in;
        rsp.sign_out   = 1'b0;
        rsp.zero_out   = 1'b0;
        rsp.sz_written = 1'b0;
        case (req.func)
            FUNC_CMA: rsp.acc_out = ~req.acc_in;
            FUNC_RLC: rsp.acc_out = {req.acc_in[6:0], req.acc_in[7]};
            FUNC_RRC: rsp.acc_out = {req.acc_in[0], req.acc_in[7:1]};
            FUNC_RAL:
            begin
                rsp.acc_out   = {req.acc_in[6:0], req.carry_in};
                rsp.carry_out = req.acc_in[7];
            end
            FUNC_RAR:
            begin
                rsp.acc_out   = {req.carry_in, req.acc_in[7:1]};
                rsp.carry_out = req.acc_in[0];
            end
            FUNC_ANA: rsp.acc_out = req.acc_in & req.operand;
            FUNC_CMP:
            begin
                // Unsigned compare: borrow lands in both sign and carry.
                rsp.sign_out   = req.acc_in < req.operand;
                rsp.zero_out   = req.acc_in == req.operand;
                rsp.carry_out  = req.acc_in < req.operand;
                rsp.sz_written = 1'b1;
            end
            FUNC_STC: rsp.carry_out = 1'b1;
            FUNC_CMC: rsp.carry_out = ~req.carry_in;
            default:  rsp.acc_out = req.acc_in;
        endcase
    end

endmodule

@@ design/lru_out_stage.sv @@
`timescale 1ns / 1ps

module lru_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  lru_pkg::rsp_t up_data,
    output logic          down_valid,
    input  logic          down_ready,
    output lru_pkg::rsp_t down_data
);
    import lru_pkg::*;

    logic valid_reg;
    rsp_t data_reg;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

endmodule

@@ design/logic_rotate_unit_8bit.sv @@
// Logical and rotate unit for an 8-bit accumulator datapath.
// Channel req carries one operation beat: func, acc_in, operand and
// carry_in. Channel rsp carries one result beat per request: acc_out,
// carry_out, sign_out, zero_out and sz_written. Both use valid/ready;
// a beat moves on a rising edge with valid and ready high.
// A request beat is captured in an input register, decoded by a short
// combinational ALU and captured in a result register that drives rsp.
// Throughput is one beat per cycle while rsp.ready stays high; both
// registers reload in the same cycle that their content moves on.
// When the receiver holds rsp.ready low, the result register keeps its
// beat, the input register still takes one more beat if it is empty,
// and after that req.ready drops until rsp drains. Nothing is lost or
// repeated. Reset (rst_n low, asynchronous) empties both registers; the
// unit keeps no other state and needs no setup.
`timescale 1ns / 1ps
`include "logic_rotate_unit_8bit_assert.svh"

module logic_rotate_unit_8bit (
    input logic   clk,
    input logic   rst_n,
    lru_req_if.sink   req,
    lru_rsp_if.source rsp
);
    import lru_pkg::*;

    req_t req_data;
    req_t mid_data;
    rsp_t alu_data;
    rsp_t out_data;
    logic mid_valid;
    logic mid_ready;

    assign req_data.func     = req.func;
    assign req_data.acc_in   = req.acc_in;
    assign req_data.operand  = req.operand;
    assign req_data.carry_in = req.carry_in;

    lru_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (req.valid),
        .up_ready   (req.ready),
        .up_data    (req_data),
        .down_valid (mid_valid),
        .down_ready (mid_ready),
        .down_data  (mid_data)
    );

    lru_alu u_alu (
        .req (mid_data),
        .rsp (alu_data)
    );

    lru_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (mid_valid),
        .up_ready   (mid_ready),
        .up_data    (alu_data),
        .down_valid (rsp.valid),
        .down_ready (rsp.ready),
        .down_data  (out_data)
    );

    assign rsp.acc_out    = out_data.acc_out;
    assign rsp.carry_out  = out_data.carry_out;
    assign rsp.sign_out   = out_data.sign_out;
    assign rsp.zero_out   = out_data.zero_out;
    assign rsp.sz_written = out_data.sz_written;

    `LRU_ASSERT_IMPLIES(a_flags_quiet, rsp.valid && !rsp.sz_written,
        !rsp.sign_out && !rsp.zero_out)
    `LRU_ASSERT_IMPLIES(a_cmp_carry, rsp.valid && rsp.sz_written,
        rsp.carry_out == rsp.sign_out)
    `LRU_ASSERT_NEVER(a_cmp_excl, rsp.valid && rsp.sign_out && rsp.zero_out)
    `LRU_ASSERT_IMPLIES(a_full_stall, mid_valid && rsp.valid && !rsp.ready,
        !req.ready)

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import lru_pkg::*;

    // Codes 9 to 15 decode to nothing; the unit must pass acc and carry through.
    localparam logic [FuncWidth-1:0] FUNC_RSV_LO = 4'd9;
    localparam logic [FuncWidth-1:0] FUNC_RSV_HI = 4'd15;

    localparam int NUM_DIRECTED = 25;
    localparam int NUM_RANDOM = 600;
    localparam int QUIET_TAIL = 100;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        req_t op;
        logic has_exp;
        rsp_t exp;
    } dir_row_t;

    // Expected results are typed in where they are plain; rows with has_exp low
    // are left to alu_result_for.
    localparam dir_row_t DirectedRows [NUM_DIRECTED] = '{
        {{FUNC_CMA, 8'h00, 8'h00, 1'b0}, 1'b1, {8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_CMA, 8'hFF, 8'hFF, 1'b1}, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RLC, 8'h80, 8'h00, 1'b0}, 1'b1, {8'h01, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RLC, 8'h01, 8'hFF, 1'b1}, 1'b1, {8'h02, 1'b1, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RRC, 8'h01, 8'h00, 1'b0}, 1'b1, {8'h80, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RRC, 8'h80, 8'hFF, 1'b1}, 1'b1, {8'h40, 1'b1, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RAL, 8'h80, 8'h00, 1'b0}, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RAL, 8'h7F, 8'h00, 1'b1}, 1'b1, {8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RAR, 8'h01, 8'h00, 1'b0}, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RAR, 8'hFE, 8'h00, 1'b1}, 1'b1, {8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_ANA, 8'hFF, 8'hFF, 1'b0}, 1'b1, {8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_ANA, 8'hAA, 8'h55, 1'b1}, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        {{FUNC_ANA, 8'h3C, 8'h0F, 1'b0}, 1'b0, {8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_CMP, 8'h00, 8'h00, 1'b1}, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        {{FUNC_CMP, 8'h00, 8'hFF, 1'b0}, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0, 1'b1}},
        {{FUNC_CMP, 8'hFF, 8'h00, 1'b1}, 1'b1, {8'hFF, 1'b0, 1'b0, 1'b0, 1'b1}},
        {{FUNC_CMP, 8'h7F, 8'h80, 1'b0}, 1'b0, {8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_STC, 8'hA5, 8'h00, 1'b0}, 1'b1, {8'hA5, 1'b1, 1'b0, 1'b0, 1'b0}},
        {{FUNC_STC, 8'h5A, 8'hFF, 1'b1}, 1'b1, {8'h5A, 1'b1, 1'b0, 1'b0, 1'b0}},
        {{FUNC_CMC, 8'h00, 8'h00, 1'b0}, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        {{FUNC_CMC, 8'hFF, 8'hFF, 1'b1}, 1'b1, {8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RSV_LO, 8'hC3, 8'h3C, 1'b1}, 1'b1, {8'hC3, 1'b1, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RSV_HI, 8'hFF, 8'hFF, 1'b0}, 1'b1, {8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RLC, 8'h96, 8'h00, 1'b0}, 1'b0, {8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        {{FUNC_RAR, 8'h69, 8'h00, 1'b1}, 1'b0, {8'h00, 1'b0, 1'b0, 1'b0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lru_req_if req_ch ();
    lru_rsp_if rsp_ch ();

    logic_rotate_unit_8bit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rsp_t pending_results [$];
    int idle_pct = 0;
    int ops_sent = 0;
    int results_checked = 0;
    int fail_count = 0;
    int func_hits [16];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_t alu_result_for(input req_t op);
        rsp_t r;
        r.acc_out = op.acc_in;
        r.carry_out = op.carry_in;
        r.sign_out = 1'b0;
        r.zero_out = 1'b0;
        r.sz_written = 1'b0;
        case (op.func)
            FUNC_CMA: r.acc_out = ~op.acc_in;
            FUNC_RLC: r.acc_out = {op.acc_in[6:0], op.acc_in[7]};
            FUNC_RRC: r.acc_out = {op.acc_in[0], op.acc_in[7:1]};
            FUNC_RAL:
            begin
                r.acc_out = {op.acc_in[6:0], op.carry_in};
                r.carry_out = op.acc_in[7];
            end
            FUNC_RAR:
            begin
                r.acc_out = {op.carry_in, op.acc_in[7:1]};
                r.carry_out = op.acc_in[0];
            end
            FUNC_ANA: r.acc_out = op.acc_in & op.operand;
            FUNC_CMP:
            begin
                r.sign_out = (op.acc_in < op.operand);
                r.zero_out = (op.acc_in == op.operand);
                r.carry_out = r.sign_out;
                r.sz_written = 1'b1;
            end
            FUNC_STC: r.carry_out = 1'b1;
            FUNC_CMC: r.carry_out = ~op.carry_in;
            default: ;
        endcase
        return r;
    endfunction

    // Holds valid high with the given payload until the beat is taken.
    task automatic send_op(input req_t op, input logic has_exp, input rsp_t exp);
        req_ch.valid <= 1'b1;
        req_ch.func <= op.func;
        req_ch.acc_in <= op.acc_in;
        req_ch.operand <= op.operand;
        req_ch.carry_in <= op.carry_in;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(has_exp ? exp : alu_result_for(op));
        func_hits[op.func]++;
        ops_sent++;
    endtask

    // Drops valid for a number of cycles with junk on the payload lines.
    task automatic hold_off(input int cycles);
        req_ch.valid <= 1'b0;
        req_ch.func <= 4'($urandom);
        req_ch.acc_in <= 8'($urandom);
        req_ch.operand <= 8'($urandom);
        req_ch.carry_in <= 1'($urandom);
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic drain_results;
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte;
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic req_t random_op;
        req_t op;
        if ($urandom_range(0, 9) == 0)
            op.func = 4'($urandom_range(FUNC_RSV_LO, FUNC_RSV_HI));
        else
            op.func = 4'($urandom_range(FUNC_CMA, FUNC_CMC));
        op.acc_in = pick_byte();
        op.operand = pick_byte();
        op.carry_in = 1'($urandom);
        // Equal and adjacent values make the compare flags interesting.
        if (op.func == FUNC_CMP)
        begin
            case ($urandom_range(0, 3))
                0: op.operand = op.acc_in;
                1: op.operand = op.acc_in + 8'd1;
                2: op.operand = op.acc_in - 8'd1;
                default: ;
            endcase
        end
        return op;
    endfunction

    initial
    begin
        req_t op;
        rsp_t unused_exp;
        unused_exp = '0;
        req_ch.valid <= 1'b0;
        req_ch.func <= FUNC_CMA;
        req_ch.acc_in <= 8'h00;
        req_ch.operand <= 8'h00;
        req_ch.carry_in <= 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_op(DirectedRows[i].op, DirectedRows[i].has_exp, DirectedRows[i].exp);
        drain_results();

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            // Idling level changes every 50 beats, with quiet stretches mixed in.
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if (i >= NUM_RANDOM - QUIET_TAIL)
                idle_pct = 0;
            if (i == NUM_RANDOM / 2)
                drain_results();
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                hold_off($urandom_range(1, 6));
            op = random_op();
            send_op(op, 1'b0, unused_exp);
        end

        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Sent %0d beats: every function code, %0d on unused codes, %0d compares.",
                 ops_sent, func_hits[9] + func_hits[10] + func_hits[11] + func_hits[12]
                 + func_hits[13] + func_hits[14] + func_hits[15], func_hits[FUNC_CMP]);
        $display("Checked %0d results with sender and receiver stalls; %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver stalls come in bursts and follow the same idling level.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(0, 5);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual acc 0x%0h",
                         $time, rsp_ch.acc_out);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("acc_out", int'(want.acc_out), int'(rsp_ch.acc_out));
                check_field("carry_out", int'(want.carry_out), int'(rsp_ch.carry_out));
                check_field("sign_out", int'(want.sign_out), int'(rsp_ch.sign_out));
                check_field("zero_out", int'(want.zero_out), int'(rsp_ch.zero_out));
                check_field("sz_written", int'(want.sz_written), int'(rsp_ch.sz_written));
                results_checked++;
            end
        end
    end

    initial
    begin
        #2ms;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
